// ===== rtl/core/smx_pkg.sv =====
`default_nettype none
package smx_pkg;

  localparam int STACK_DEPTH = 512;
  localparam int CODE_DEPTH  = 1024;
  localparam int SA_W        = $clog2(STACK_DEPTH);
  localparam int SP_W        = SA_W + 1;
  localparam int PC_W        = $clog2(CODE_DEPTH);
  localparam int WORD_W      = 32;
  localparam int WIDE_W      = WORD_W + 2;

  typedef logic signed [WIDE_W-1:0] wide_t;

  // instruction codes
  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LIT  = 4'd1,
    OP_OPR  = 4'd2,
    OP_LOD  = 4'd3,
    OP_STO  = 4'd4,
    OP_CAL  = 4'd5,
    OP_RTN  = 4'd6,
    OP_INC  = 4'd7,
    OP_JMP  = 4'd8,
    OP_JPC  = 4'd9,
    OP_SYS  = 4'd10
  } op_t;

  // opr sub-codes
  localparam logic [WORD_W-1:0] OPR_ADD = 32'd1;
  localparam logic [WORD_W-1:0] OPR_SUB = 32'd2;
  localparam logic [WORD_W-1:0] OPR_MUL = 32'd3;
  localparam logic [WORD_W-1:0] OPR_DIV = 32'd4;
  localparam logic [WORD_W-1:0] OPR_EQL = 32'd5;
  localparam logic [WORD_W-1:0] OPR_NEQ = 32'd6;
  localparam logic [WORD_W-1:0] OPR_LSS = 32'd7;
  localparam logic [WORD_W-1:0] OPR_LEQ = 32'd8;
  localparam logic [WORD_W-1:0] OPR_GTR = 32'd9;
  localparam logic [WORD_W-1:0] OPR_GEQ = 32'd10;

  // sys sub-codes
  localparam logic [WORD_W-1:0] SYS_WRITE = 32'd1;
  localparam logic [WORD_W-1:0] SYS_READ  = 32'd2;
  localparam logic [WORD_W-1:0] SYS_HALT  = 32'd3;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_HALT  = 2'd1,
    ST_DIV0  = 2'd2,
    ST_FAULT = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD_Y, S_RD_X, S_ALU, S_DIVW, S_WALK,
    S_WALKW, S_LOD, S_STO, S_CAL2, S_CAL3, S_RTN1, S_RTN2, S_JPC, S_SYSW,
    S_FINISH
  } state_t;

  function automatic logic in_stack(input wide_t v);
    return (v >= 0) && (v < STACK_DEPTH);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/smx_div.sv =====
`default_nettype none
module smx_div
  import smx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   done,
  output logic [WORD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic [WORD_W:0]   rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              act;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;

  // one quotient bit per cycle, restoring
  assign shifted  = {rem[WORD_W-1:0], quo[WORD_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign done     = act && (cnt == '0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      act <= 1'b1;
      cnt <= CNT_W'(WORD_W);
    end else if (done) begin
      act <= 1'b0;
    end else if (act) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (act && (cnt != '0)) begin
      if (!diff[WORD_W]) begin
        rem <= diff;
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/stack_machine_execute_unit.sv =====
`default_nettype none
// Execute stage of a PL/0-style stack machine.
// Input channel s_axis: one word per fetched instruction (op, lev, m) and the
// value that a SYS read pushes. Output channel m_axis: one word per
// instruction with the next fetch address, a status, and the value popped by
// a SYS write (write_valid marks it).
// Stack, base pointer, stack pointer, program counter and halt flag live
// inside. The stack is a single 512-word memory with one write and one
// registered read per cycle. Each static link followed costs one more stack
// read, and a divide waits on the 32-step bit-serial divider.
// One instruction is in work at a time; the next one is taken the cycle
// after the result enters the output register, even if that result is still
// waiting. A stalled receiver holds the result; the unit finishes the next
// instruction and then waits until the output register frees up.
// After reset the unit sweeps all 512 stack words to zero, one word a cycle,
// with s_axis_tready low. After a fault or halt, every instruction
// returns the stopping address and status and changes nothing.
module stack_machine_execute_unit
  import smx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // op[3:0], lev[6:4], m[38:7], read_value[70:39]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // next_pc[9:0], status[11:10], write_valid[12],
                                           // write_value[44:13]
);

  // stack memory
  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic              mem_we;
  logic [SA_W-1:0]   mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [SA_W-1:0]   mem_raddr;
  logic [WORD_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // architectural and work registers
  state_t            state, state_next;
  logic [SA_W-1:0]   clr_cnt;
  logic [SA_W-1:0]   bp, bp_next;
  logic [SP_W-1:0]   sp, sp_next;
  logic [PC_W-1:0]   pc, pc_next;
  logic              halted, halted_next;
  status_t           reason, reason_next;
  op_t               op_r;
  logic [2:0]        lev_r;
  logic [WORD_W-1:0] m_r, rv_r;
  logic [WORD_W-1:0] b, b_next;
  logic [2:0]        cnt, cnt_next;
  logic [WORD_W-1:0] x, x_next, y, y_next;
  logic [SA_W-1:0]   addr, addr_next;
  logic [PC_W-1:0]   res_pc, res_pc_next;
  status_t           res_st, res_st_next;
  logic              res_wv, res_wv_next;
  logic [WORD_W-1:0] res_wval, res_wval_next;
  logic              out_valid;
  logic [PC_W-1:0]   out_pc;
  status_t           out_st;
  logic              out_wv;
  logic [WORD_W-1:0] out_wval;
  logic              in_acc, out_load;

  // divider
  logic              div_start, div_done;
  logic [WORD_W-1:0] div_a, div_b, div_q, quo_s;

  // completion controls
  logic              fail, done, done_halt, done_wv;
  status_t           fail_code;
  logic [PC_W-1:0]   done_pc;
  logic [WORD_W-1:0] done_wval;

  // derived values
  wide_t             sp_w, sm_w, b_w, bp_w, sp_p1, sp_m1, sp_p3, a_w, inc_w;
  logic [PC_W-1:0]   npc;
  logic signed [WORD_W-1:0] sx, sy;
  logic [WORD_W-1:0] alu_r;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_FINISH) && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_wval, out_wv, out_st, out_pc};

  assign sp_w  = WIDE_W'(signed'(sp));
  assign sm_w  = WIDE_W'(signed'(m_r));
  assign b_w   = signed'({2'b00, b});
  assign bp_w  = signed'({(WIDE_W - SA_W)'(0), bp});
  assign sp_p1 = sp_w + 1;
  assign sp_m1 = sp_w - 1;
  assign sp_p3 = sp_w + 3;
  assign a_w   = b_w + sm_w;
  assign inc_w = sp_w + sm_w;
  assign npc   = pc + 1'b1;
  assign sx    = signed'(x);
  assign sy    = signed'(y);

  // divide on magnitudes, sign restored afterwards
  assign div_a = x[WORD_W-1] ? (~x + 1'b1) : x;
  assign div_b = y[WORD_W-1] ? (~y + 1'b1) : y;
  assign quo_s = (x[WORD_W-1] ^ y[WORD_W-1]) ? (~div_q + 1'b1) : div_q;

  smx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // alu for the non-divide operations
  always_comb begin
    case (m_r)
      OPR_ADD: alu_r = x + y;
      OPR_SUB: alu_r = x - y;
      OPR_MUL: alu_r = x * y;
      OPR_EQL: alu_r = {31'd0, sx == sy};
      OPR_NEQ: alu_r = {31'd0, sx != sy};
      OPR_LSS: alu_r = {31'd0, sx < sy};
      OPR_LEQ: alu_r = {31'd0, sx <= sy};
      OPR_GTR: alu_r = {31'd0, sx > sy};
      default: alu_r = {31'd0, sx >= sy};
    endcase
  end

  // sequencer
  always_comb begin
    state_next    = state;
    bp_next       = bp;
    sp_next       = sp;
    pc_next       = pc;
    halted_next   = halted;
    reason_next   = reason;
    b_next        = b;
    cnt_next      = cnt;
    x_next        = x;
    y_next        = y;
    addr_next     = addr;
    res_pc_next   = res_pc;
    res_st_next   = res_st;
    res_wv_next   = res_wv;
    res_wval_next = res_wval;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    div_start     = 1'b0;
    fail          = 1'b0;
    fail_code     = ST_FAULT;
    done          = 1'b0;
    done_halt     = 1'b0;
    done_pc       = npc;
    done_wv       = 1'b0;
    done_wval     = '0;

    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        if (clr_cnt == SA_W'(STACK_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (halted) begin
          res_pc_next   = pc;
          res_st_next   = reason;
          res_wv_next   = 1'b0;
          res_wval_next = '0;
          state_next    = S_FINISH;
        end else begin
          case (op_r)
            OP_LIT: begin
              if (!in_stack(sp_p1)) begin
                fail = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = sp_p1[SA_W-1:0];
                mem_wdata = m_r;
                sp_next   = sp_p1[SP_W-1:0];
                done      = 1'b1;
              end
            end
            OP_OPR: begin
              if (m_r < OPR_ADD || m_r > OPR_GEQ) begin
                done = 1'b1;
              end else if (!in_stack(sp_w) || !in_stack(sp_m1)) begin
                fail = 1'b1;
              end else begin
                mem_raddr  = sp_w[SA_W-1:0];
                state_next = S_RD_Y;
              end
            end
            OP_LOD, OP_STO, OP_CAL: begin
              b_next     = {(WORD_W - SA_W)'(0), bp};
              cnt_next   = '0;
              state_next = S_WALK;
            end
            OP_RTN: begin
              if (!in_stack(bp_w + 2)) begin
                fail = 1'b1;
              end else begin
                mem_raddr  = bp + 1'b1;
                state_next = S_RTN1;
              end
            end
            OP_INC: begin
              if (inc_w < -1 || inc_w >= STACK_DEPTH) begin
                fail = 1'b1;
              end else begin
                sp_next = inc_w[SP_W-1:0];
                done    = 1'b1;
              end
            end
            OP_JMP: begin
              done_pc = m_r[PC_W-1:0];
              done    = 1'b1;
            end
            OP_JPC: begin
              if (!in_stack(sp_w)) begin
                fail = 1'b1;
              end else begin
                mem_raddr  = sp_w[SA_W-1:0];
                state_next = S_JPC;
              end
            end
            OP_SYS: begin
              if (m_r == SYS_WRITE) begin
                if (!in_stack(sp_w)) begin
                  fail = 1'b1;
                end else begin
                  mem_raddr  = sp_w[SA_W-1:0];
                  state_next = S_SYSW;
                end
              end else if (m_r == SYS_READ) begin
                if (!in_stack(sp_p1)) begin
                  fail = 1'b1;
                end else begin
                  mem_we    = 1'b1;
                  mem_waddr = sp_p1[SA_W-1:0];
                  mem_wdata = rv_r;
                  sp_next   = sp_p1[SP_W-1:0];
                  done      = 1'b1;
                end
              end else begin
                done_halt = (m_r == SYS_HALT);
                done      = 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_RD_Y: begin
        y_next     = rd_data;
        mem_raddr  = sp_m1[SA_W-1:0];
        state_next = S_RD_X;
      end
      S_RD_X: begin
        x_next     = rd_data;
        state_next = S_ALU;
      end
      S_ALU: begin
        if (m_r == OPR_DIV) begin
          if (y == '0) begin
            fail      = 1'b1;
            fail_code = ST_DIV0;
          end else begin
            div_start  = 1'b1;
            state_next = S_DIVW;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = sp_m1[SA_W-1:0];
          mem_wdata = alu_r;
          sp_next   = sp_m1[SP_W-1:0];
          done      = 1'b1;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_waddr = sp_m1[SA_W-1:0];
          mem_wdata = quo_s;
          sp_next   = sp_m1[SP_W-1:0];
          done      = 1'b1;
        end
      end
      // static-link walk, then the access that needs the frame base
      S_WALK: begin
        if (!in_stack(b_w)) begin
          fail = 1'b1;
        end else if (cnt != lev_r) begin
          mem_raddr  = b[SA_W-1:0];
          state_next = S_WALKW;
        end else begin
          case (op_r)
            OP_LOD: begin
              if (!in_stack(a_w) || !in_stack(sp_p1)) begin
                fail = 1'b1;
              end else begin
                mem_raddr  = a_w[SA_W-1:0];
                state_next = S_LOD;
              end
            end
            OP_STO: begin
              if (!in_stack(a_w) || !in_stack(sp_w)) begin
                fail = 1'b1;
              end else begin
                mem_raddr  = sp_w[SA_W-1:0];
                addr_next  = a_w[SA_W-1:0];
                state_next = S_STO;
              end
            end
            default: begin
              if (!in_stack(sp_p3)) begin
                fail = 1'b1;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = sp_p1[SA_W-1:0];
                mem_wdata  = b;
                state_next = S_CAL2;
              end
            end
          endcase
        end
      end
      S_WALKW: begin
        b_next     = rd_data;
        cnt_next   = cnt + 1'b1;
        state_next = S_WALK;
      end
      S_LOD: begin
        mem_we    = 1'b1;
        mem_waddr = sp_p1[SA_W-1:0];
        mem_wdata = rd_data;
        sp_next   = sp_p1[SP_W-1:0];
        done      = 1'b1;
      end
      S_STO: begin
        mem_we    = 1'b1;
        mem_waddr = addr;
        mem_wdata = rd_data;
        sp_next   = sp_m1[SP_W-1:0];
        done      = 1'b1;
      end
      S_CAL2: begin
        mem_we     = 1'b1;
        mem_waddr  = SA_W'(sp_w + 2);
        mem_wdata  = {(WORD_W - SA_W)'(0), bp};
        state_next = S_CAL3;
      end
      S_CAL3: begin
        mem_we    = 1'b1;
        mem_waddr = sp_p3[SA_W-1:0];
        mem_wdata = {(WORD_W - PC_W)'(0), npc};
        bp_next   = sp_p1[SA_W-1:0];
        done_pc   = m_r[PC_W-1:0];
        done      = 1'b1;
      end
      S_RTN1: begin
        b_next     = rd_data;
        mem_raddr  = bp + 2'd2;
        state_next = S_RTN2;
      end
      S_RTN2: begin
        if (!in_stack(b_w)) begin
          fail = 1'b1;
        end else begin
          sp_next = SP_W'(bp_w - 1);
          bp_next = b[SA_W-1:0];
          done_pc = rd_data[PC_W-1:0];
          done    = 1'b1;
        end
      end
      S_JPC: begin
        if (rd_data == '0) begin
          done_pc = m_r[PC_W-1:0];
        end
        sp_next = sp_m1[SP_W-1:0];
        done    = 1'b1;
      end
      S_SYSW: begin
        sp_next   = sp_m1[SP_W-1:0];
        done_wv   = 1'b1;
        done_wval = rd_data;
        done      = 1'b1;
      end
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // retire: a fault changes nothing but the halt state
    if (fail) begin
      halted_next   = 1'b1;
      reason_next   = fail_code;
      res_pc_next   = pc;
      res_st_next   = fail_code;
      res_wv_next   = 1'b0;
      res_wval_next = '0;
      state_next    = S_FINISH;
    end else if (done) begin
      pc_next       = done_pc;
      res_pc_next   = done_pc;
      res_st_next   = done_halt ? ST_HALT : ST_RUN;
      res_wv_next   = done_wv;
      res_wval_next = done_wval;
      if (done_halt) begin
        halted_next = 1'b1;
        reason_next = ST_HALT;
      end
      state_next = S_FINISH;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      bp        <= '0;
      sp        <= '1;
      pc        <= '0;
      halted    <= 1'b0;
      reason    <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt + 1'b1;
      bp      <= bp_next;
      sp      <= sp_next;
      pc      <= pc_next;
      halted  <= halted_next;
      reason  <= reason_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= op_t'(s_axis_tdata[3:0]);
      lev_r <= s_axis_tdata[6:4];
      m_r   <= s_axis_tdata[38:7];
      rv_r  <= s_axis_tdata[70:39];
    end
    b        <= b_next;
    cnt      <= cnt_next;
    x        <= x_next;
    y        <= y_next;
    addr     <= addr_next;
    res_pc   <= res_pc_next;
    res_st   <= res_st_next;
    res_wv   <= res_wv_next;
    res_wval <= res_wval_next;
    if (out_load) begin
      out_pc   <= res_pc;
      out_st   <= res_st;
      out_wv   <= res_wv;
      out_wval <= res_wval;
    end
  end

  // once halted, the unit stays halted until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag dropped");

  // a fault result always comes with the halt flag set
  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_st == ST_DIV0 || out_st == ST_FAULT)) |-> halted)
    else $error("fault reported while running");

  // no stack write while waiting for or holding a word
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FINISH) |-> !mem_we)
    else $error("stack written outside an instruction");

  // a write word is never reported with a fault status
  a_write_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_wv) |-> (out_st == ST_RUN))
    else $error("write word with bad status");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

import smx_pkg::*;

// one expected result word
typedef struct {
  logic [9:0]  next_pc;
  status_t     status;
  logic        write_valid;
  logic [31:0] write_value;
} exec_result_t;

// shadow machine: predicts each result and keeps the queue of pending results
class exec_predictor;
  logic [31:0]  mem [STACK_DEPTH];
  longint       sp;
  longint       bp;
  logic [9:0]   pc;
  bit           stopped;
  status_t      stop_reason;
  exec_result_t pending_q [$];
  int           errors;

  function new();
    foreach (mem[i]) mem[i] = '0;
    sp = -1;
    bp = 0;
    pc = '0;
    stopped = 0;
    stop_reason = ST_RUN;
    errors = 0;
  endfunction

  function bit in_range(longint a);
    return a >= 0 && a < STACK_DEPTH;
  endfunction

  // follow lev static links from the base pointer
  function bit walk(int lev, output longint b);
    b = bp;
    for (int i = 0; i < lev; i++) begin
      if (!in_range(b)) return 0;
      b = longint'(mem[b]);
    end
    return in_range(b);
  endfunction

  function void note(logic [3:0] op, logic [2:0] lev, logic [31:0] m, logic [31:0] rv);
    longint       s, b, a, sm, sx, sy;
    logic [9:0]   npc;
    status_t      st;
    logic         wv;
    logic [31:0]  wval, x, y, r;
    exec_result_t e;
    if (stopped) begin
      e = '{pc, stop_reason, 1'b0, 32'd0};
      pending_q.push_back(e);
      return;
    end
    s = sp;
    sm = longint'($signed(m));
    npc = pc + 10'd1;
    st = ST_RUN;
    wv = 0;
    wval = '0;
    r = '0;
    case (op)
      OP_LIT: begin
        if (!in_range(s + 1)) st = ST_FAULT;
        else begin
          mem[s + 1] = m;
          s++;
        end
      end
      OP_OPR: begin
        if (m >= OPR_ADD && m <= OPR_GEQ) begin
          if (!in_range(s) || !in_range(s - 1)) st = ST_FAULT;
          else begin
            x = mem[s - 1];
            y = mem[s];
            sx = longint'($signed(x));
            sy = longint'($signed(y));
            case (m)
              OPR_ADD: r = x + y;
              OPR_SUB: r = x - y;
              OPR_MUL: r = x * y;
              OPR_DIV: begin
                // quotient in 64 bits so the overflow case wraps
                if (y == 0) st = ST_DIV0;
                else r = 32'(sx / sy);
              end
              OPR_EQL: r = {31'd0, sx == sy};
              OPR_NEQ: r = {31'd0, sx != sy};
              OPR_LSS: r = {31'd0, sx < sy};
              OPR_LEQ: r = {31'd0, sx <= sy};
              OPR_GTR: r = {31'd0, sx > sy};
              default: r = {31'd0, sx >= sy};
            endcase
            if (st == ST_RUN) begin
              mem[s - 1] = r;
              s--;
            end
          end
        end
      end
      OP_LOD: begin
        if (!walk(lev, b)) st = ST_FAULT;
        else begin
          a = b + sm;
          if (!in_range(a) || !in_range(s + 1)) st = ST_FAULT;
          else begin
            mem[s + 1] = mem[a];
            s++;
          end
        end
      end
      OP_STO: begin
        if (!walk(lev, b)) st = ST_FAULT;
        else begin
          a = b + sm;
          if (!in_range(a) || !in_range(s)) st = ST_FAULT;
          else begin
            mem[a] = mem[s];
            s--;
          end
        end
      end
      OP_CAL: begin
        if (!walk(lev, b)) st = ST_FAULT;
        else if (!in_range(s + 3)) st = ST_FAULT;
        else begin
          mem[s + 1] = 32'(b);
          mem[s + 2] = 32'(bp);
          mem[s + 3] = {22'd0, npc};
          bp = s + 1;
          npc = m[9:0];
        end
      end
      OP_RTN: begin
        b = bp;
        if (!in_range(b + 2)) st = ST_FAULT;
        else if (!in_range(longint'(mem[b + 1]))) st = ST_FAULT;
        else begin
          s = b - 1;
          npc = mem[b + 2][9:0];
          bp = longint'(mem[b + 1]);
        end
      end
      OP_INC: begin
        a = s + sm;
        if (a < -1 || a >= STACK_DEPTH) st = ST_FAULT;
        else s = a;
      end
      OP_JMP: npc = m[9:0];
      OP_JPC: begin
        if (!in_range(s)) st = ST_FAULT;
        else begin
          if (mem[s] == 0) npc = m[9:0];
          s--;
        end
      end
      OP_SYS: begin
        if (m == SYS_WRITE) begin
          if (!in_range(s)) st = ST_FAULT;
          else begin
            wv = 1;
            wval = mem[s];
            s--;
          end
        end else if (m == SYS_READ) begin
          if (!in_range(s + 1)) st = ST_FAULT;
          else begin
            mem[s + 1] = rv;
            s++;
          end
        end else if (m == SYS_HALT) begin
          st = ST_HALT;
        end
      end
      default: ;
    endcase
    // faults keep the pc at the faulting instruction
    if (st == ST_DIV0 || st == ST_FAULT) begin
      stopped = 1;
      stop_reason = st;
      npc = pc;
      wv = 0;
      wval = '0;
    end else begin
      sp = s;
      pc = npc;
      if (st == ST_HALT) begin
        stopped = 1;
        stop_reason = ST_HALT;
      end
    end
    e = '{npc, st, wv, wval};
    pending_q.push_back(e);
  endfunction

  function void check(logic [47:0] word);
    exec_result_t e;
    bit           bad;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word %h", word);
      return;
    end
    e = pending_q.pop_front();
    bad = (word[9:0] !== e.next_pc) || (word[11:10] !== e.status) ||
          (word[12] !== e.write_valid) || (word[44:13] !== e.write_value);
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp pc %0d st %0d wv %0b val %h, got pc %0d st %0d wv %0b val %h",
                 e.next_pc, e.status, e.write_valid, e.write_value,
                 word[9:0], word[11:10], word[12], word[44:13]);
    end
  endfunction
endclass

module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 1000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [47:0] m_axis_tdata;

  exec_predictor model;
  bit            no_idle = 0;
  int            rx_stall = 0;
  int            quiet_cycles = 0;

  stack_machine_execute_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= 0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      rx_stall <= $urandom_range(0, 17);
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) model.check(m_axis_tdata);
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drive one instruction word and wait for it to be taken
  task automatic send_word(logic [3:0] op, logic [2:0] lev, logic [31:0] m,
                           logic [31:0] rv);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {1'b0, rv, m, lev, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    model.note(op, lev, m, rv);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // pick a random instruction that keeps the machine running
  task automatic random_word();
    logic [3:0]  op;
    logic [2:0]  lev;
    logic [31:0] m;
    longint      b, a, sp;
    int          k, v;
    bit          ok;
    ok = 0;
    while (!ok) begin
      k = $urandom_range(0, 99);
      sp = model.sp;
      lev = 3'($urandom);
      m = $urandom;
      ok = 1;
      if (k < 5) begin
        v = $urandom_range(0, 5);
        op = (v == 0) ? 4'd0 : 4'(10 + v);
      end else if (k < 22) begin
        op = OP_LIT;
        ok = sp < 400;
        if ($urandom_range(0, 2) == 0) m = $urandom_range(0, 3);
      end else if (k < 42) begin
        op = OP_OPR;
        ok = sp >= 1;
        m = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 11);
        if (ok && m == OPR_DIV && model.mem[sp] == 0) m = OPR_ADD;
      end else if (k < 60) begin
        // loads and stores aim inside the live stack
        op = (k < 52) ? OP_LOD : OP_STO;
        ok = (op == OP_LOD) ? sp < 400 : sp >= 0;
        while (!model.walk(lev, b)) lev--;
        a = $urandom_range(0, (sp < 0) ? 0 : int'(sp));
        m = 32'(a - b);
      end else if (k < 65) begin
        op = OP_CAL;
        ok = sp < 400;
        while (!model.walk(lev, b)) lev--;
      end else if (k < 70) begin
        op = OP_RTN;
        ok = model.in_range(model.bp + 2) &&
             model.in_range(longint'(model.mem[model.bp + 1]));
      end else if (k < 76) begin
        op = OP_INC;
        m = 32'($urandom_range(0, 8) - 3);
        a = sp + longint'($signed(m));
        ok = a >= -1 && a <= 400;
      end else if (k < 82) begin
        op = OP_JMP;
      end else if (k < 88) begin
        op = OP_JPC;
        ok = sp >= 0;
      end else begin
        op = OP_SYS;
        v = $urandom_range(0, 4);
        if (v < 2) begin
          m = SYS_WRITE;
          ok = sp >= 0;
        end else if (v < 4) begin
          m = SYS_READ;
          ok = sp < 400;
        end else if (m >= SYS_WRITE && m <= SYS_HALT) begin
          m = 32'd0;
        end
      end
    end
    send_word(op, lev, m, $urandom);
  endtask

  initial begin
    model = new();
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: overflowing divide, then each opr against a fresh literal
    send_word(OP_LIT, 3'd0, 32'h8000_0000, 32'd0);
    send_word(OP_LIT, 3'd0, 32'hFFFF_FFFF, 32'd0);
    send_word(OP_OPR, 3'd0, OPR_DIV, 32'd0);
    for (int s = 1; s <= 10; s++) begin
      send_word(OP_LIT, 3'd0, (s == 4) ? 32'hFFFF_FFF9 : $urandom, 32'd0);
      send_word(OP_OPR, 3'd0, 32'(s), 32'd0);
    end
    // call, frame access through a static link, return
    send_word(OP_CAL, 3'd0, 32'hFFFF_FFFF, 32'd0);
    send_word(OP_INC, 3'd0, 32'd3, 32'd0);
    send_word(OP_LIT, 3'd0, 32'h7FFF_FFFF, 32'd0);
    send_word(OP_STO, 3'd0, 32'd3, 32'd0);
    send_word(OP_LOD, 3'd1, 32'd0, 32'd0);
    send_word(OP_INC, 3'd0, 32'hFFFF_FFFF, 32'd0);
    send_word(OP_RTN, 3'd7, 32'd0, 32'd0);
    send_word(OP_JPC, 3'd0, 32'd100, 32'd0);
    send_word(OP_SYS, 3'd0, SYS_READ, 32'h8000_0001);
    send_word(OP_SYS, 3'd0, SYS_WRITE, 32'd0);
    send_word(4'd15, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_OPR, 3'd0, 32'd0, 32'd0);
    send_word(OP_SYS, 3'd0, 32'd7, 32'd0);
    send_word(OP_JMP, 3'd0, 32'hFFFF_FFFF, 32'd0);

    // random program
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        s_axis_tvalid <= 0;
        while (model.pending_q.size() != 0) @(posedge clk);
      end
      if (i == RANDOM_ITEMS * 85 / 100) no_idle = 1;
      random_word();
    end

    // end the run with one way of stopping, then show the stopped state
    case ($urandom_range(0, 2))
      0: begin
        send_word(OP_LIT, 3'd0, 32'd5, 32'd0);
        send_word(OP_LIT, 3'd0, 32'd0, 32'd0);
        send_word(OP_OPR, 3'd0, OPR_DIV, 32'd0);
      end
      1: send_word(OP_INC, 3'd0, 32'd600, 32'd0);
      default: send_word(OP_SYS, 3'd0, SYS_HALT, 32'd0);
    endcase
    repeat (5) random_word();
    s_axis_tvalid <= 0;

    while (model.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (model.errors == 0 && model.pending_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
